// ===== rtl/pet_pkg.sv =====
// Shared widths and limits for the trial-division prime enumerator.
// No dependencies; imported by prime_enumerator_trial_division_core.
package pet_pkg;

	// Width of the bound, the candidates and the primes.
	localparam int unsigned VAL_W = 9;

	// Width of a trial divisor: d*d <= 311 keeps d at 17, and the loop ends at 18.
	localparam int unsigned DIV_W = 5;

	// Bit counter for one serial division, counting 0 .. VAL_W-1.
	localparam int unsigned CNT_W = 4;

	// Largest bound honored; larger requests saturate to it.
	localparam logic [VAL_W-1:0] BOUND_CAP = 9'd311;

	// First candidate and first divisor.
	localparam logic [VAL_W-1:0] FIRST_CAND = 9'd2;
	localparam logic [DIV_W-1:0] FIRST_DIV  = 5'd2;

endpackage

// ===== rtl/prime_enumerator_trial_division_core.sv =====
// Top level of the trial-division prime enumerator.
// Depends on pet_pkg for widths and the bound cap.
//
// A request (start high while busy is low) carries an upper bound; the core then
// reports every prime from 2 up to that bound, in ascending order, one per valid
// strobe, with is_last set on the final one. Bounds above 311 are treated as 311,
// and a bound below 2 ends the request with no results. The receiver cannot stall:
// each result is shown for exactly one cycle. The core handles one request at a
// time and holds busy high until its last result has been issued. Each trial
// division is a bit-serial restoring remainder, led by a check of the divisor
// square. Each candidate also passes through a bound check and an increment step,
// and each prime through one more square check, the one that finds no divisor.
module prime_enumerator_trial_division_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [pet_pkg::VAL_W-1:0] upper_bound,
	output logic                      valid,
	output logic [pet_pkg::VAL_W-1:0] prime_value,
	output logic                      is_last
);
	import pet_pkg::*;

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CAND = 3'd1;
	localparam logic [2:0] ST_TEST = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_NEXT = 3'd4;

	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VAL_W - 1);

	logic [2:0]       state_q;
	logic [VAL_W-1:0] bound_q;
	logic [VAL_W-1:0] cand_q;
	logic [DIV_W-1:0] div_q;
	logic [VAL_W-1:0] sh_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] pend_q;
	logic             pend_valid_q;
	logic             valid_q;
	logic [VAL_W-1:0] prime_q;
	logic             last_q;

	logic [2*DIV_W-1:0] div_sq;
	logic               div_past;
	logic [DIV_W:0]     rem_shift;
	logic               rem_ge;
	logic [DIV_W:0]     rem_next;
	logic [VAL_W-1:0]   bound_sat;

	// Saturate the requested bound to the cap.
	assign bound_sat = (upper_bound > BOUND_CAP) ? BOUND_CAP : upper_bound;

	// The divisor loop stops once d*d exceeds the candidate.
	assign div_sq   = {{DIV_W{1'b0}}, div_q} * {{DIV_W{1'b0}}, div_q};
	assign div_past = div_sq > {{(2*DIV_W-VAL_W){1'b0}}, cand_q};

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	assign rem_shift = {rem_q, sh_q[VAL_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, div_q};
	assign rem_next  = rem_ge ? (rem_shift - {1'b0, div_q}) : rem_shift;

	assign busy        = state_q != ST_IDLE;
	assign valid       = valid_q;
	assign prime_value = prime_q;
	assign is_last     = last_q;

	// Control state: sequencer, pending prime and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_CAND;
					end
				end
				ST_CAND: begin
					if (cand_q > bound_q) begin
						// Run is over: the prime held back is the last one.
						valid_q <= pend_valid_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (div_past) begin
						// No divisor found: issue the previous prime, hold this one.
						valid_q      <= pend_valid_q;
						pend_valid_q <= 1'b1;
						state_q      <= ST_NEXT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == LAST_BIT) begin
						state_q <= (rem_next == '0) ? ST_NEXT : ST_TEST;
					end
				end
				ST_NEXT: begin
					state_q <= ST_CAND;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: candidate, divisor, serial remainder and results.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bound_q <= bound_sat;
				cand_q  <= FIRST_CAND;
			end
			ST_CAND: begin
				div_q   <= FIRST_DIV;
				prime_q <= pend_q;
				last_q  <= 1'b1;
			end
			ST_TEST: begin
				sh_q  <= cand_q;
				rem_q <= '0;
				cnt_q <= '0;
				if (div_past) begin
					prime_q <= pend_q;
					last_q  <= 1'b0;
					pend_q  <= cand_q;
				end
			end
			ST_DIV: begin
				sh_q  <= {sh_q[VAL_W-2:0], 1'b0};
				rem_q <= rem_next[DIV_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					div_q <= div_q + 1'b1;
				end
			end
			ST_NEXT: begin
				cand_q <= cand_q + 1'b1;
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
	end

	// A reported prime lies within the range of the capped bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (prime_value >= FIRST_CAND) && (prime_value <= BOUND_CAP))
		else $error("prime out of range");

	// An earlier prime of a run is always followed by more work.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !is_last |-> busy)
		else $error("non-final prime while idle");

	// The final prime comes out as the core goes idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_last |-> !busy)
		else $error("final prime while still busy");

	// An accepted request makes the core busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not taken");

endmodule
